### src/ppvc_pkg.sv
// ppvc_pkg: field widths, codes, defaults and shared types of the pressure pulse
// vehicle counter.
// No dependencies.
`timescale 1ns / 1ps

package ppvc_pkg;

   localparam int SAMPLE_W = 10;
   localparam int COUNT_W  = 16;
   localparam int THRESH_W = 8;

   localparam int GROUP_SIZE_DEFAULT    = 10;
   localparam int FRACTION_BITS_DEFAULT = 8;

   // baseline moves one tenth of the way per step
   localparam int EMA_DIVISOR = 10;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd3;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hFFFF;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_ACK    = 1'b1;

   typedef struct packed {
      logic group_done;
      logic pulse_seen;
      logic vehicle_added;
   } flags_type;

endpackage

### src/ppvc_ifs.sv
// ppvc_req_if / ppvc_rsp_if: valid/ready channels for sensor items and results.
// Depends on ppvc_pkg.
`timescale 1ns / 1ps

interface ppvc_req_if;
   import ppvc_pkg::*;

   logic                valid;
   logic                ready;
   logic                cmd;
   logic [SAMPLE_W-1:0] sample;
   logic                in_warmup;
   logic                ack_ok;
   logic [COUNT_W-1:0]  ack_amount;

   modport source (output valid, cmd, sample, in_warmup, ack_ok, ack_amount, input ready);
   modport sink   (input valid, cmd, sample, in_warmup, ack_ok, ack_amount, output ready);
endinterface

interface ppvc_rsp_if;
   import ppvc_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] vehicle_count;
   logic               group_done;
   logic               pulse_seen;
   logic               vehicle_added;

   modport source (output valid, vehicle_count, group_done, pulse_seen, vehicle_added,
                   input ready);
   modport sink   (input valid, vehicle_count, group_done, pulse_seen, vehicle_added,
                   output ready);
endinterface

### src/ppvc_group.sv
// ppvc_group: sample accumulation and truncated group mean.
// Depends on ppvc_pkg.
`timescale 1ns / 1ps

module ppvc_group #(
   parameter int GROUP_SIZE = ppvc_pkg::GROUP_SIZE_DEFAULT,
   parameter int SUM_W      = $clog2(GROUP_SIZE * 1023 + 1),
   parameter int POS_W      = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1
) (
   input  logic [SUM_W-1:0]              group_sum,
   input  logic [POS_W-1:0]              group_pos,
   input  logic [ppvc_pkg::SAMPLE_W-1:0] sample,
   output logic [SUM_W-1:0]              sum_next,
   output logic [POS_W-1:0]              pos_next,
   output logic                          complete,
   output logic [ppvc_pkg::SAMPLE_W-1:0] mean
);
   import ppvc_pkg::*;

   // exact division by a constant: multiply by ceil(2^SHIFT / GROUP_SIZE)
   localparam int SHIFT  = SUM_W + $clog2(GROUP_SIZE);
   localparam int PROD_W = SUM_W + SHIFT + 1;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE);
   localparam logic [SHIFT:0] RECIP = RECIP_L[SHIFT:0];
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(GROUP_SIZE - 1);

   logic [SUM_W-1:0]  sum_add;
   logic [PROD_W-1:0] prod;

   assign sum_add  = group_sum + SUM_W'(sample);
   assign complete = (group_pos == LAST_POS);
   assign prod     = PROD_W'(sum_add) * PROD_W'(RECIP);
   assign mean     = prod[SHIFT +: SAMPLE_W];
   assign sum_next = complete ? '0 : sum_add;
   assign pos_next = complete ? '0 : group_pos + POS_W'(1);

endmodule

### src/ppvc_ema.sv
// ppvc_ema: one baseline step of a tenth toward a target, truncated toward zero.
// Depends on ppvc_pkg.
`timescale 1ns / 1ps

module ppvc_ema #(
   parameter int FRACTION_BITS = ppvc_pkg::FRACTION_BITS_DEFAULT,
   parameter int BASE_W        = ppvc_pkg::SAMPLE_W + FRACTION_BITS
) (
   input  logic [BASE_W-1:0]             baseline,
   input  logic [ppvc_pkg::SAMPLE_W-1:0] target,
   output logic [BASE_W-1:0]             baseline_next
);
   import ppvc_pkg::*;

   localparam int SHIFT  = BASE_W + $clog2(EMA_DIVISOR);
   localparam int PROD_W = BASE_W + SHIFT + 1;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + 64'(EMA_DIVISOR) - 64'd1) / 64'(EMA_DIVISOR);
   localparam logic [SHIFT:0] RECIP = RECIP_L[SHIFT:0];

   logic [BASE_W-1:0] target_q;
   logic              rising;
   logic [BASE_W-1:0] diff;
   logic [PROD_W-1:0] prod;
   logic [BASE_W-1:0] step;

   assign target_q = {target, {FRACTION_BITS{1'b0}}};
   assign rising   = (target_q >= baseline);
   assign diff     = rising ? (target_q - baseline) : (baseline - target_q);
   assign prod     = PROD_W'(diff) * PROD_W'(RECIP);
   assign step     = prod[SHIFT +: BASE_W];
   assign baseline_next = rising ? (baseline + step) : (baseline - step);

endmodule

### src/ppvc_update.sv
// ppvc_update: next state and result flags for one item.
// Depends on ppvc_pkg, ppvc_group and ppvc_ema.
`timescale 1ns / 1ps

module ppvc_update #(
   parameter int GROUP_SIZE    = ppvc_pkg::GROUP_SIZE_DEFAULT,
   parameter int FRACTION_BITS = ppvc_pkg::FRACTION_BITS_DEFAULT,
   parameter int SUM_W         = $clog2(GROUP_SIZE * 1023 + 1),
   parameter int POS_W         = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1,
   parameter int BASE_W        = ppvc_pkg::SAMPLE_W + FRACTION_BITS
) (
   input  logic                          cmd,
   input  logic [ppvc_pkg::SAMPLE_W-1:0] sample,
   input  logic                          in_warmup,
   input  logic                          ack_ok,
   input  logic [ppvc_pkg::COUNT_W-1:0]  ack_amount,
   input  logic [ppvc_pkg::THRESH_W-1:0] threshold,
   input  logic [ppvc_pkg::COUNT_W-1:0]  count,
   input  logic                          parity,
   input  logic [BASE_W-1:0]             baseline,
   input  logic [SUM_W-1:0]              group_sum,
   input  logic [POS_W-1:0]              group_pos,
   input  logic [ppvc_pkg::SAMPLE_W-1:0] last_mean,
   output logic [ppvc_pkg::COUNT_W-1:0]  count_next,
   output logic                          parity_next,
   output logic [BASE_W-1:0]             baseline_next,
   output logic [SUM_W-1:0]              group_sum_next,
   output logic [POS_W-1:0]              group_pos_next,
   output logic [ppvc_pkg::SAMPLE_W-1:0] last_mean_next,
   output ppvc_pkg::flags_type           flags
);
   import ppvc_pkg::*;

   logic [SUM_W-1:0]    grp_sum;
   logic [POS_W-1:0]    grp_pos;
   logic                grp_complete;
   logic [SAMPLE_W-1:0] mean;
   logic [SAMPLE_W-1:0] ema_target;
   logic [BASE_W-1:0]   ema_out;
   logic [BASE_W:0]     limit;
   logic [BASE_W:0]     mean_q;
   logic                pulse;

   ppvc_group #(
      .GROUP_SIZE (GROUP_SIZE),
      .SUM_W      (SUM_W),
      .POS_W      (POS_W)
   ) u_group (
      .group_sum (group_sum),
      .group_pos (group_pos),
      .sample    (sample),
      .sum_next  (grp_sum),
      .pos_next  (grp_pos),
      .complete  (grp_complete),
      .mean      (mean)
   );

   // warm-up steps toward the last finished mean, a finished group toward its own
   assign ema_target = in_warmup ? last_mean : mean;

   ppvc_ema #(
      .FRACTION_BITS (FRACTION_BITS),
      .BASE_W        (BASE_W)
   ) u_ema (
      .baseline      (baseline),
      .target        (ema_target),
      .baseline_next (ema_out)
   );

   assign limit  = (BASE_W+1)'(baseline) +
                   (BASE_W+1)'({threshold, {FRACTION_BITS{1'b0}}});
   assign mean_q = (BASE_W+1)'({mean, {FRACTION_BITS{1'b0}}});
   assign pulse  = (mean_q > limit) && (baseline[FRACTION_BITS-1:0] != '0);

   always_comb begin
      count_next     = count;
      parity_next    = parity;
      baseline_next  = baseline;
      group_sum_next = group_sum;
      group_pos_next = group_pos;
      last_mean_next = last_mean;
      flags          = '0;
      if (cmd == CMD_ACK) begin
         if (ack_ok) begin
            count_next = (ack_amount >= count) ? '0 : (count - ack_amount);
         end
      end else if (in_warmup) begin
         baseline_next = ema_out;
      end else begin
         group_sum_next = grp_sum;
         group_pos_next = grp_pos;
         if (grp_complete) begin
            last_mean_next   = mean;
            flags.group_done = 1'b1;
            if (pulse) begin
               flags.pulse_seen = 1'b1;
               parity_next      = ~parity;
               baseline_next    = mean_q[BASE_W-1:0];
               // second pulse of a pair brings parity back to one
               if (!parity) begin
                  flags.vehicle_added = 1'b1;
                  if (count != COUNT_MAX) begin
                     count_next = count + COUNT_W'(1);
                  end
               end
            end else begin
               baseline_next = ema_out;
            end
         end
      end
   end

endmodule

### src/pressure_pulse_vehicle_counter.sv
// pressure_pulse_vehicle_counter: top level, channel registers and counter state.
// Depends on ppvc_pkg, ppvc_ifs and ppvc_update.
//
// Usage:
//   req_bus carries one item per transfer: a pressure sample (cmd = sample)
//   or a server acknowledge (cmd = ack) that lowers the count.
//   rsp_bus returns exactly one result per item, in order: the vehicle count
//   after the item and the group_done / pulse_seen / vehicle_added flags.
//   csr_wr_en / csr_wr_data write the pulse threshold; write only while idle.
//   A request transfer loads the input register, and the result register is loaded
//   from it once the result register is empty or the receiver takes its result.
//   Throughput: one item per cycle while the receiver does not stall; the whole
//   state update for an item is combinational between the input register and
//   the result register, so the next item sees it immediately.
//   When the receiver stalls, the result register holds and the input register
//   still takes one more item; req_bus.ready drops only when both are full.
//   Reset (synchronous, active high) clears count, baseline and group, sets the
//   pulse parity to one and the threshold to 3; both channels come up empty.
`timescale 1ns / 1ps

module pressure_pulse_vehicle_counter #(
   parameter int GROUP_SIZE    = ppvc_pkg::GROUP_SIZE_DEFAULT,
   parameter int FRACTION_BITS = ppvc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   ppvc_req_if.sink                      req_bus,
   ppvc_rsp_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [ppvc_pkg::THRESH_W-1:0] csr_wr_data
);
   import ppvc_pkg::*;

   localparam int SUM_W  = $clog2(GROUP_SIZE * 1023 + 1);
   localparam int POS_W  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam int BASE_W = SAMPLE_W + FRACTION_BITS;

   // input register
   logic                in_valid_ff;
   logic                cmd_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                warm_ff;
   logic                ack_ok_ff;
   logic [COUNT_W-1:0]  ack_amount_ff;

   // result register
   logic               out_valid_ff;
   logic [COUNT_W-1:0] out_count_ff;
   flags_type          out_flags_ff;

   // block state
   logic [THRESH_W-1:0] thresh_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                parity_ff;
   logic [BASE_W-1:0]   baseline_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [SAMPLE_W-1:0] last_mean_ff;

   logic [COUNT_W-1:0]  count_in;
   logic                parity_in;
   logic [BASE_W-1:0]   baseline_in;
   logic [SUM_W-1:0]    sum_in;
   logic [POS_W-1:0]    pos_in;
   logic [SAMPLE_W-1:0] last_mean_in;
   flags_type           flags_in;

   logic advance;
   logic req_xfer;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_xfer = req_bus.valid && req_bus.ready;

   ppvc_update #(
      .GROUP_SIZE    (GROUP_SIZE),
      .FRACTION_BITS (FRACTION_BITS),
      .SUM_W         (SUM_W),
      .POS_W         (POS_W),
      .BASE_W        (BASE_W)
   ) u_update (
      .cmd            (cmd_ff),
      .sample         (sample_ff),
      .in_warmup      (warm_ff),
      .ack_ok         (ack_ok_ff),
      .ack_amount     (ack_amount_ff),
      .threshold      (thresh_ff),
      .count          (count_ff),
      .parity         (parity_ff),
      .baseline       (baseline_ff),
      .group_sum      (sum_ff),
      .group_pos      (pos_ff),
      .last_mean      (last_mean_ff),
      .count_next     (count_in),
      .parity_next    (parity_in),
      .baseline_next  (baseline_in),
      .group_sum_next (sum_in),
      .group_pos_next (pos_in),
      .last_mean_next (last_mean_in),
      .flags          (flags_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         thresh_ff    <= THRESH_RESET;
         count_ff     <= '0;
         parity_ff    <= 1'b1;
         baseline_ff  <= '0;
         sum_ff       <= '0;
         pos_ff       <= '0;
         last_mean_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            count_ff     <= count_in;
            parity_ff    <= parity_in;
            baseline_ff  <= baseline_in;
            sum_ff       <= sum_in;
            pos_ff       <= pos_in;
            last_mean_ff <= last_mean_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff        <= req_bus.cmd;
         sample_ff     <= req_bus.sample;
         warm_ff       <= req_bus.in_warmup;
         ack_ok_ff     <= req_bus.ack_ok;
         ack_amount_ff <= req_bus.ack_amount;
      end
      if (advance) begin
         out_count_ff <= count_in;
         out_flags_ff <= flags_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.vehicle_count = out_count_ff;
   assign rsp_bus.group_done    = out_flags_ff.group_done;
   assign rsp_bus.pulse_seen    = out_flags_ff.pulse_seen;
   assign rsp_bus.vehicle_added = out_flags_ff.vehicle_added;

endmodule
